@@ rtl/core/gmnc_pkg.sv @@
`timescale 1ns / 1ps
package gmnc_pkg;

  // Input kinds carried on tuser
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // Work queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  // Configuration view handed to the front
  typedef struct packed {
    logic [7:0] num_rows;
    logic [7:0] num_cols;
    logic       restart;
  } cfg_t;

  // One classified input word: up to two results share one 3x3 window
  typedef struct packed {
    logic [6:0] row;
    logic [6:0] col;
    logic [8:0] win;
    logic       emit_a;
    logic       emit_b;
    logic       last;
  } entry_t;

  // One result word
  typedef struct packed {
    logic [6:0] row;
    logic [6:0] col;
    logic       is_mine;
    logic [3:0] count;
    logic       last;
  } result_t;

  // Count mines around the center of a 3x3 window; zero for a mine center
  function automatic logic [3:0] mine_count(input logic [8:0] w);
    logic [3:0] n;
    n = '0;
    if (!w[4]) begin
      for (int i = 0; i < 9; i++) begin
        if (i != 4) begin
          n = n + 4'(w[i]);
        end
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/core/gmnc_front.sv @@
`timescale 1ns / 1ps
module gmnc_front #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gmnc_pkg::cfg_t    cfg_i,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              opcode_i,
  input  logic              mine_i,
  input  logic              full_i,
  output logic              push_o,
  output gmnc_pkg::entry_t  entry_o
);
  import gmnc_pkg::*;

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW1 = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [8:0]     win_q, win_d;
  logic [RW-1:0]  nr_eff;
  logic [CW1-1:0] nc_eff;
  logic           acc;
  logic           col_last, row_last;
  logic           mine_eff;
  logic [1:0]     prev, rbuf, wdata;
  logic [2:0]     column;
  logic [8:0]     win_base, win_new;

  // Line buffer: bit 0 previous row, bit 1 two rows back
  logic [1:0] line_mem [MAX_COLS];
  logic [1:0] rd_q;
  logic [1:0] byp_data_q;
  logic       byp_q;

  // Clamp the register values to the supported grid
  always_comb begin
    if (cfg_i.num_rows == 8'd0) begin
      nr_eff = RW'(1);
    end else if (int'(cfg_i.num_rows) > MAX_ROWS) begin
      nr_eff = RW'(MAX_ROWS);
    end else begin
      nr_eff = RW'(cfg_i.num_rows);
    end
    if (cfg_i.num_cols == 8'd0) begin
      nc_eff = CW1'(1);
    end else if (int'(cfg_i.num_cols) > MAX_COLS) begin
      nc_eff = CW1'(MAX_COLS);
    end else begin
      nc_eff = CW1'(cfg_i.num_cols);
    end
  end

  assign s_ready_o = !full_i;
  assign acc       = s_valid_i && s_ready_o;
  assign col_last  = (CW1'(col_q) + CW1'(1)) == nc_eff;
  assign row_last  = (row_q == nr_eff);

  // Build the new window column from the line buffer and the incoming cell
  assign mine_eff = (opcode_i == OP_CELL) && !row_last && mine_i;
  assign rbuf     = byp_q ? byp_data_q : rd_q;
  assign prev     = (row_q == '0) ? 2'b00 : rbuf;
  assign column   = {mine_eff, prev[0], prev[1]};
  assign wdata    = {prev[0], mine_eff};
  assign win_base = (col_q == '0) ? 9'd0 : win_q;
  assign win_new  = {column, win_base[8:3]};

  // Advance the raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    if (cfg_i.restart) begin
      col_d = '0;
      row_d = '0;
      win_d = '0;
    end else if (acc) begin
      win_d = win_new;
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
      byp_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      win_q <= win_d;
      byp_q <= acc && (col_q == col_d);
    end
  end

  // Write the current column, prefetch the next one
  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_mem[col_q] <= wdata;
    end
    rd_q       <= line_mem[col_d];
    byp_data_q <= wdata;
  end

  // Hand the classified word to the queue
  always_comb begin
    entry_o.row    = 7'(row_q - RW'(1));
    entry_o.col    = 7'(col_q);
    entry_o.win    = win_new;
    entry_o.emit_a = (row_q != '0) && (col_q != '0);
    entry_o.emit_b = (row_q != '0) && col_last;
    entry_o.last   = row_last;
  end

  assign push_o = acc && (entry_o.emit_a || entry_o.emit_b);

endmodule

@@ rtl/core/gmnc_queue.sv @@
`timescale 1ns / 1ps
module gmnc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gmnc_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output gmnc_pkg::entry_t  entry_o
);
  import gmnc_pkg::*;

  entry_t         slot_q [QDEPTH];
  logic [QPW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPW:0]   cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == (QPW + 1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Move the pointers and the fill level
  always_comb begin
    wr_d  = do_push ? wr_q + QPW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPW'(1) : rd_q;
    cnt_d = cnt_q + (QPW + 1)'(do_push) - (QPW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/core/gmnc_back.sv @@
`timescale 1ns / 1ps
module gmnc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  gmnc_pkg::entry_t  entry_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output gmnc_pkg::result_t res_o
);
  import gmnc_pkg::*;

  logic    valid_q, valid_d;
  logic    phase_q, phase_d;
  logic    load, take_a;
  logic [8:0] win;
  result_t res_q, res_d;

  assign load   = !valid_q || m_ready_i;
  assign take_a = !phase_q && entry_i.emit_a;

  // Pick the left-neighbor result first, then the row-end result
  always_comb begin
    res_d.row = entry_i.row;
    if (take_a) begin
      res_d.col  = entry_i.col - 7'd1;
      win        = entry_i.win;
      res_d.last = 1'b0;
    end else begin
      res_d.col  = entry_i.col;
      win        = {3'b000, entry_i.win[8:3]};
      res_d.last = entry_i.last;
    end
    res_d.is_mine = win[4];
    res_d.count   = mine_count(win);
  end

  // Retire the queue word once its last result is loaded
  always_comb begin
    pop_o   = 1'b0;
    phase_d = phase_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = valid_i;
      if (valid_i) begin
        if (take_a && entry_i.emit_b) begin
          phase_d = 1'b1;
        end else begin
          pop_o   = 1'b1;
          phase_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      res_q <= res_d;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule

@@ rtl/core/grid_mine_neighbor_count.sv @@
`timescale 1ns / 1ps
// Streaming 3x3 mine-neighbor counter. Mine flags arrive in raster order, one word per cycle,
// and the block takes one input word every cycle while the output side keeps up. A result is
// the count of mines around a cell one row up and one column left of the input; each row of
// num_cols inputs yields num_cols results, the row-end input yields two, and a four-word queue
// between the classifying front and the result back absorbs that burst, so the sustained rate is
// one input word per cycle, limited by the single result register of the output. The line
// buffer is one memory port pair, read one column ahead with a bypass for one-column grids. After
// each frame send num_cols flush words (tuser = 1) to drain the last row. A register write
// restarts the frame. No clearing pass is needed after reset: rows above row 0 read as empty.
module grid_mine_neighbor_count #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] mine, [7:1] zero
  input  logic        s_axis_tuser,   // [0] opcode: 0 grid cell, 1 flush
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] out_row, [13:7] out_col, [14] is_mine,
                                      // [18:15] neighbor_count, [23:19] zero
  output logic        m_axis_tlast,   // frame_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gmnc_pkg::*;

  logic       [7:0] num_rows_q, num_cols_q;
  logic             cfg_we;
  cfg_t             cfg;
  entry_t           q_in, q_out;
  logic             q_push, q_pop, q_full, q_valid;
  result_t          res;

  // Register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= 8'd1;
      num_cols_q <= 8'd1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_NUM_COLS) begin
        num_cols_q <= pwdata[7:0];
      end else begin
        num_rows_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NUM_COLS) ? {24'd0, num_cols_q} : {24'd0, num_rows_q};

  always_comb begin
    cfg.num_rows = num_rows_q;
    cfg.num_cols = num_cols_q;
    cfg.restart  = cfg_we;
  end

  gmnc_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .opcode_i  (s_axis_tuser),
    .mine_i    (s_axis_tdata[0]),
    .full_i    (q_full),
    .push_o    (q_push),
    .entry_o   (q_in)
  );

  gmnc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  gmnc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .entry_i   (q_out),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {5'd0, res.count, res.is_mine, res.col, res.row};
  assign m_axis_tlast = res.last;

  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("push into full work queue");

  // The queue only drains through the back
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(q_valid) |-> $past(q_pop))
    else $error("work queue emptied without a pop");

  // A mine cell reports no neighbors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[14]) |-> (m_axis_tdata[18:15] == 4'd0))
    else $error("mine cell with nonzero count");

endmodule
